// ===== rtl/core/hhfp_pkg.sv =====
// Shared types, character constants and prefix tables for the HTTP header
// field parser. No dependencies.
package hhfp_pkg;

    localparam int unsigned LEN_W = 32;
    localparam int unsigned CNT_W = 7;

    localparam logic [7:0] CR_CHAR    = 8'h0D;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] SEMI_CHAR  = 8'h3B;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] NUL_CHAR   = 8'h00;

    localparam logic [4:0] CL_LEN  = 5'd16;
    localparam logic [4:0] CT_LEN  = 5'd14;
    localparam logic [3:0] KEY_LEN = 4'd9;

    typedef enum logic [7:0] {
        PH_REQUEST = 8'b0000_0001,
        PH_SKIP    = 8'b0000_0010,
        PH_PREFIX  = 8'b0000_0100,
        PH_CLVAL   = 8'b0000_1000,
        PH_CTKEY   = 8'b0001_0000,
        PH_CTCAP   = 8'b0010_0000,
        PH_CTDONE  = 8'b0100_0000,
        PH_IGNORE  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [CNT_W-1:0] count;
        logic             cut;
        logic             bank;
    } hhfp_status_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [CNT_W-1:0] slot;
        logic [7:0]       data;
    } hhfp_wr_t;

    // "Content-Length: "
    function automatic logic [7:0] cl_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h43;
            5'd1:    c = 8'h6F;
            5'd2:    c = 8'h6E;
            5'd3:    c = 8'h74;
            5'd4:    c = 8'h65;
            5'd5:    c = 8'h6E;
            5'd6:    c = 8'h74;
            5'd7:    c = 8'h2D;
            5'd8:    c = 8'h4C;
            5'd9:    c = 8'h65;
            5'd10:   c = 8'h6E;
            5'd11:   c = 8'h67;
            5'd12:   c = 8'h74;
            5'd13:   c = 8'h68;
            5'd14:   c = 8'h3A;
            5'd15:   c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Content-Type: "
    function automatic logic [7:0] ct_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h43;
            5'd1:    c = 8'h6F;
            5'd2:    c = 8'h6E;
            5'd3:    c = 8'h74;
            5'd4:    c = 8'h65;
            5'd5:    c = 8'h6E;
            5'd6:    c = 8'h74;
            5'd7:    c = 8'h2D;
            5'd8:    c = 8'h54;
            5'd9:    c = 8'h79;
            5'd10:   c = 8'h70;
            5'd11:   c = 8'h65;
            5'd12:   c = 8'h3A;
            5'd13:   c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "boundary="
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h62;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h75;
            4'd3:    c = 8'h6E;
            4'd4:    c = 8'h64;
            4'd5:    c = 8'h61;
            4'd6:    c = 8'h72;
            4'd7:    c = 8'h79;
            4'd8:    c = 8'h3D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/http_header_field_parser_core.sv =====
// HTTP header field parser, top level: input channel, result run engine
// and boundary store. Depends on hhfp_pkg, hhfp_parser and hhfp_ram.
//
// Usage: header bytes enter on the data channel (data_valid/data_stall),
// one word per cycle, with end_of_headers low. A word with end_of_headers
// high closes the header block. It starts a run of result words on the
// result channel (result_valid/result_stall): one word per stored boundary
// byte, or a single word with boundary_byte 0 when no boundary byte is stored.
// Every word of a run carries the same content_length, boundary_length and
// boundary_truncated; last_result marks the final one.
// Throughput: one data word per cycle while data_stall is low; data_stall
// is high while words of a run are still to be issued. Once the end word
// is taken the run registers load, and each result word is read from the
// RAM into the result stage. Boundary bytes sit in a two-bank RAM (one
// bank being filled, one committed), read one byte per cycle into the
// result stage. When result_stall is high the result word holds and the
// run pauses. Reset clears the parser to the start of a request line and
// empties the result stage; the boundary RAM needs no clearing.
module http_header_field_parser_core #(
    parameter int unsigned MAX_BOUNDARY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_headers,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] content_length,
    output logic [6:0]  boundary_length,
    output logic [7:0]  boundary_byte,
    output logic        boundary_truncated,
    output logic        last_result
);
    import hhfp_pkg::*;

    localparam int unsigned IDX_W  = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;
    localparam int unsigned ADDR_W = IDX_W + 1;
    localparam int unsigned DEPTH  = 2 ** ADDR_W;

    hhfp_status_t     status;
    hhfp_wr_t         wr;
    logic             accept;
    logic             load;
    logic             last_item;
    logic [7:0]       rd_byte;
    logic [CNT_W-1:0] idx_inc;

    logic             run_active_reg, run_active_next;
    logic [CNT_W-1:0] run_idx_reg,    run_idx_next;
    logic [CNT_W-1:0] run_total_reg,  run_total_next;
    logic [LEN_W-1:0] run_len_reg,    run_len_next;
    logic [CNT_W-1:0] run_count_reg,  run_count_next;
    logic             run_cut_reg,    run_cut_next;
    logic             run_bank_reg,   run_bank_next;

    logic             out_valid_reg,  out_valid_next;
    logic [LEN_W-1:0] out_len_reg,    out_len_next;
    logic [CNT_W-1:0] out_count_reg,  out_count_next;
    logic             out_cut_reg,    out_cut_next;
    logic             out_last_reg,   out_last_next;
    logic             out_zero_reg,   out_zero_next;

    assign data_stall = run_active_reg;
    assign accept     = data_valid && !run_active_reg;
    assign load       = run_active_reg && (!out_valid_reg || !result_stall);
    assign idx_inc    = run_idx_reg + CNT_W'(1);
    assign last_item  = (idx_inc == run_total_reg);

    hhfp_parser #(
        .MAX_BOUNDARY(MAX_BOUNDARY)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_headers(end_of_headers),
        .status        (status),
        .wr            (wr)
    );

    hhfp_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (wr.en),
        .waddr({wr.bank, wr.slot[IDX_W-1:0]}),
        .wdata(wr.data),
        .re   (load),
        .raddr({run_bank_reg, run_idx_reg[IDX_W-1:0]}),
        .rdata(rd_byte)
    );

    always_comb
    begin
        run_active_next = run_active_reg;
        run_idx_next    = run_idx_reg;
        run_total_next  = run_total_reg;
        run_len_next    = run_len_reg;
        run_count_next  = run_count_reg;
        run_cut_next    = run_cut_reg;
        run_bank_next   = run_bank_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_len_next    = out_len_reg;
        out_count_next  = out_count_reg;
        out_cut_next    = out_cut_reg;
        out_last_next   = out_last_reg;
        out_zero_next   = out_zero_reg;

        if (accept && end_of_headers)
        begin
            run_active_next = 1'b1;
            run_idx_next    = '0;
            run_total_next  = (status.count == '0) ? CNT_W'(1) : status.count;
            run_len_next    = status.length;
            run_count_next  = status.count;
            run_cut_next    = status.cut;
            run_bank_next   = status.bank;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            out_len_next   = run_len_reg;
            out_count_next = run_count_reg;
            out_cut_next   = run_cut_reg;
            out_last_next  = last_item;
            out_zero_next  = (run_count_reg == '0);
            run_idx_next   = idx_inc;
            if (last_item)
            begin
                run_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            run_idx_reg    <= '0;
            run_total_reg  <= '0;
            run_bank_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            out_zero_reg   <= 1'b1;
        end
        else
        begin
            run_active_reg <= run_active_next;
            run_idx_reg    <= run_idx_next;
            run_total_reg  <= run_total_next;
            run_bank_reg   <= run_bank_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
            out_zero_reg   <= out_zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_len_reg   <= run_len_next;
        run_count_reg <= run_count_next;
        run_cut_reg   <= run_cut_next;
        out_len_reg   <= out_len_next;
        out_count_reg <= out_count_next;
        out_cut_reg   <= out_cut_next;
    end

    assign result_valid       = out_valid_reg;
    assign content_length     = out_len_reg;
    assign boundary_length    = out_count_reg;
    assign boundary_byte      = out_zero_reg ? 8'd0 : rd_byte;
    assign boundary_truncated = out_cut_reg;
    assign last_result        = out_last_reg;

endmodule

// ===== rtl/core/hhfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hhfp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/hhfp_parser.sv =====
// Per-byte header line parser: line tracking, prefix match, length
// accumulation and boundary capture. Depends on hhfp_pkg.
module hhfp_parser #(
    parameter int unsigned MAX_BOUNDARY = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_headers,
    output hhfp_pkg::hhfp_status_t status,
    output hhfp_pkg::hhfp_wr_t     wr
);
    import hhfp_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOUNDARY);

    phase_t           phase_reg,    phase_next;
    logic [4:0]       pos_reg,      pos_next;
    logic [1:0]       cand_reg,     cand_next;
    logic [3:0]       key_reg,      key_next;
    logic [LEN_W-1:0] acc_reg,      acc_next;
    logic [LEN_W-1:0] length_reg,   length_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic             cut_reg,      cut_next;
    logic             bank_reg,     bank_next;
    logic [CNT_W-1:0] pend_cnt_reg, pend_cnt_next;
    logic             pend_cut_reg, pend_cut_next;
    logic             ended_reg,    ended_next;

    logic             cl_hit;
    logic             ct_hit;
    logic [4:0]       pos_inc;
    logic             key_hit;
    logic [3:0]       key_step;
    logic [LEN_W-1:0] acc_mac;

    assign pos_inc  = pos_reg + 5'd1;
    assign cl_hit   = cand_reg[0] && (pos_reg < CL_LEN) && (data_byte == cl_char(pos_reg));
    assign ct_hit   = cand_reg[1] && (pos_reg < CT_LEN) && (data_byte == ct_char(pos_reg));
    assign key_hit  = (key_reg < KEY_LEN) && (data_byte == key_char(key_reg));
    assign key_step = key_hit ? (key_reg + 4'd1)
                              : ((data_byte == key_char(4'd0)) ? 4'd1 : 4'd0);
    assign acc_mac  = (acc_reg << 3) + (acc_reg << 1) + {24'd0, data_byte}
                    - {24'd0, ZERO_CHAR};

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        cand_next     = cand_reg;
        key_next      = key_reg;
        acc_next      = acc_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        cut_next      = cut_reg;
        bank_next     = bank_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_cut_next = pend_cut_reg;
        ended_next    = ended_reg;
        wr.en         = 1'b0;
        wr.bank       = ~bank_reg;
        wr.slot       = pend_cnt_reg;
        wr.data       = data_byte;

        if (accept)
        begin
            if (end_of_headers)
            begin
                phase_next    = PH_REQUEST;
                pos_next      = 5'd0;
                cand_next     = 2'b11;
                key_next      = 4'd0;
                acc_next      = '0;
                length_next   = '0;
                count_next    = '0;
                cut_next      = 1'b0;
                pend_cnt_next = '0;
                pend_cut_next = 1'b0;
                ended_next    = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_REQUEST:
                    begin
                        if (data_byte == CR_CHAR)
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        phase_next    = PH_PREFIX;
                        pos_next      = 5'd0;
                        cand_next     = 2'b11;
                        key_next      = 4'd0;
                        acc_next      = '0;
                        pend_cnt_next = '0;
                        pend_cut_next = 1'b0;
                        ended_next    = 1'b0;
                    end
                    default:
                    begin
                        if (data_byte == CR_CHAR)
                        begin
                            // commit the finished line
                            case (phase_reg)
                                PH_CLVAL:
                                begin
                                    length_next = acc_reg;
                                end
                                PH_CTKEY:
                                begin
                                    count_next = '0;
                                    cut_next   = 1'b0;
                                end
                                PH_CTCAP, PH_CTDONE:
                                begin
                                    bank_next  = ~bank_reg;
                                    count_next = pend_cnt_reg;
                                    cut_next   = pend_cut_reg;
                                end
                                default:
                                begin
                                end
                            endcase
                            phase_next = PH_SKIP;
                        end
                        else if (!ended_reg)
                        begin
                            if (data_byte == NUL_CHAR)
                            begin
                                ended_next = 1'b1;
                                if (phase_reg == PH_PREFIX)
                                begin
                                    phase_next = PH_IGNORE;
                                end
                            end
                            else
                            begin
                                case (phase_reg)
                                    PH_PREFIX:
                                    begin
                                        cand_next = {ct_hit, cl_hit};
                                        pos_next  = pos_inc;
                                        if (!cl_hit && !ct_hit)
                                        begin
                                            phase_next = PH_IGNORE;
                                        end
                                        else if (cl_hit && (pos_inc == CL_LEN))
                                        begin
                                            phase_next = PH_CLVAL;
                                            acc_next   = '0;
                                        end
                                        else if (ct_hit && (pos_inc == CT_LEN))
                                        begin
                                            phase_next = PH_CTKEY;
                                            key_next   = 4'd0;
                                        end
                                    end
                                    PH_CLVAL:
                                    begin
                                        acc_next = (data_byte == SPACE_CHAR) ? '0 : acc_mac;
                                    end
                                    PH_CTKEY:
                                    begin
                                        key_next = key_step;
                                        if (key_step >= KEY_LEN)
                                        begin
                                            phase_next    = PH_CTCAP;
                                            pend_cnt_next = '0;
                                            pend_cut_next = 1'b0;
                                        end
                                    end
                                    PH_CTCAP:
                                    begin
                                        if (data_byte == SEMI_CHAR)
                                        begin
                                            phase_next = PH_CTDONE;
                                        end
                                        else if (pend_cnt_reg < MAX_CNT)
                                        begin
                                            wr.en         = 1'b1;
                                            pend_cnt_next = pend_cnt_reg + CNT_W'(1);
                                        end
                                        else
                                        begin
                                            pend_cut_next = 1'b1;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_REQUEST;
            pos_reg      <= 5'd0;
            cand_reg     <= 2'b11;
            key_reg      <= 4'd0;
            acc_reg      <= '0;
            length_reg   <= '0;
            count_reg    <= '0;
            cut_reg      <= 1'b0;
            bank_reg     <= 1'b0;
            pend_cnt_reg <= '0;
            pend_cut_reg <= 1'b0;
            ended_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            cand_reg     <= cand_next;
            key_reg      <= key_next;
            acc_reg      <= acc_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            cut_reg      <= cut_next;
            bank_reg     <= bank_next;
            pend_cnt_reg <= pend_cnt_next;
            pend_cut_reg <= pend_cut_next;
            ended_reg    <= ended_next;
        end
    end

    assign status.length = length_reg;
    assign status.count  = count_reg;
    assign status.cut    = cut_reg;
    assign status.bank   = bank_reg;

endmodule

// ===== tb/http_header_field_parser_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the HTTP header field parser: watches the data and result channels,
// predicts each run of result words and compares them with what the block issues.
// Depends on hhfp_pkg.
module http_header_field_parser_checker #(
    parameter int unsigned MAX_BOUNDARY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    input  logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_headers,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] content_length,
    input  logic [6:0]  boundary_length,
    input  logic [7:0]  boundary_byte,
    input  logic        boundary_truncated,
    input  logic        last_result,
    output int          fail_count,
    output int          outstanding
);
    import hhfp_pkg::*;

    localparam logic [127:0] LENGTH_TAG = "Content-Length: ";
    localparam logic [127:0] TYPE_TAG   = "Content-Type: ";
    localparam logic [127:0] KEY_TAG    = "boundary=";

    typedef struct packed {
        logic [31:0] length;
        logic [6:0]  count;
        logic [7:0]  data;
        logic        cut;
        logic        last;
    } run_word_t;

    phase_t      phase;
    logic [4:0]  tag_pos;
    logic [1:0]  tag_hits;
    logic [3:0]  key_pos;
    logic [31:0] length_sum;
    logic [31:0] length_kept;
    logic [7:0]  boundary_kept [64];
    logic [6:0]  kept_count;
    logic        kept_cut;
    logic [7:0]  boundary_line [64];
    logic [6:0]  line_count;
    logic        line_cut;
    logic        text_done;

    run_word_t   run_q[$];
    run_word_t   seen_word;
    int          run_len;
    int          errors;

    function automatic logic [7:0] tag_char(input logic [127:0] tag, input int n, input int i);
        return tag[8*(n-1-i) +: 8];
    endfunction

    function automatic int field_diff(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic clear_parser();
        phase       = PH_REQUEST;
        tag_pos     = '0;
        tag_hits    = 2'b11;
        key_pos     = '0;
        length_sum  = '0;
        length_kept = '0;
        kept_count  = '0;
        kept_cut    = 1'b0;
        line_count  = '0;
        line_cut    = 1'b0;
        text_done   = 1'b0;
    endtask

    task automatic take_byte(input logic [7:0] b);
        logic [1:0] hits;
        hits = 2'b00;
        if (phase == PH_REQUEST)
        begin
            if (b == CR_CHAR)
                phase = PH_SKIP;
        end
        else if (phase == PH_SKIP)
        begin
            phase      = PH_PREFIX;
            tag_pos    = '0;
            tag_hits   = 2'b11;
            key_pos    = '0;
            length_sum = '0;
            line_count = '0;
            line_cut   = 1'b0;
            text_done  = 1'b0;
        end
        else if (b == CR_CHAR)
        begin
            if (phase == PH_CLVAL)
                length_kept = length_sum;
            else if (phase == PH_CTKEY)
            begin
                kept_count = '0;
                kept_cut   = 1'b0;
            end
            else if (phase == PH_CTCAP || phase == PH_CTDONE)
            begin
                boundary_kept = boundary_line;
                kept_count    = line_count;
                kept_cut      = line_cut;
            end
            phase = PH_SKIP;
        end
        else if (!text_done)
        begin
            if (b == NUL_CHAR)
            begin
                text_done = 1'b1;
                if (phase == PH_PREFIX)
                    phase = PH_IGNORE;
            end
            else
            begin
                case (phase)
                    PH_PREFIX:
                    begin
                        if (tag_hits[0] && tag_pos < CL_LEN
                            && b == tag_char(LENGTH_TAG, CL_LEN, tag_pos))
                            hits[0] = 1'b1;
                        if (tag_hits[1] && tag_pos < CT_LEN
                            && b == tag_char(TYPE_TAG, CT_LEN, tag_pos))
                            hits[1] = 1'b1;
                        tag_hits = hits;
                        tag_pos  = tag_pos + 5'd1;
                        if (hits == 2'b00)
                            phase = PH_IGNORE;
                        else if (hits[0] && tag_pos == CL_LEN)
                        begin
                            phase      = PH_CLVAL;
                            length_sum = '0;
                        end
                        else if (hits[1] && tag_pos == CT_LEN)
                        begin
                            phase   = PH_CTKEY;
                            key_pos = '0;
                        end
                    end
                    PH_CLVAL:
                    begin
                        if (b == SPACE_CHAR)
                            length_sum = '0;
                        else
                            length_sum = length_sum * 32'd10 + {24'd0, b}
                                         - {24'd0, ZERO_CHAR};
                    end
                    PH_CTKEY:
                    begin
                        if (key_pos < KEY_LEN && b == tag_char(KEY_TAG, KEY_LEN, key_pos))
                            key_pos = key_pos + 4'd1;
                        else
                            key_pos = (b == tag_char(KEY_TAG, KEY_LEN, 0)) ? 4'd1 : 4'd0;
                        if (key_pos >= KEY_LEN)
                        begin
                            phase      = PH_CTCAP;
                            line_count = '0;
                            line_cut   = 1'b0;
                        end
                    end
                    PH_CTCAP:
                    begin
                        if (b == SEMI_CHAR)
                            phase = PH_CTDONE;
                        else if (line_count < MAX_BOUNDARY)
                        begin
                            boundary_line[line_count[5:0]] = b;
                            line_count = line_count + 7'd1;
                        end
                        else
                            line_cut = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            run_q.delete();
            errors = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (data_valid && !data_stall)
            begin
                if (end_of_headers)
                begin
                    run_len = (kept_count == 0) ? 1 : int'(kept_count);
                    for (int k = 0; k < run_len; k++)
                        run_q.push_back('{length: length_kept,
                                          count:  kept_count,
                                          data:   (kept_count == 0) ? 8'd0 : boundary_kept[k],
                                          cut:    kept_cut,
                                          last:   (k == run_len - 1)});
                    clear_parser();
                end
                else
                    take_byte(data_byte);
            end
            if (result_valid && !result_stall)
            begin
                if (run_q.size() == 0)
                begin
                    $display("%0t: result word expected none actual length %0h byte %0h",
                             $time, content_length, boundary_byte);
                    errors++;
                end
                else
                begin
                    seen_word = run_q.pop_front();
                    errors += field_diff("content_length", seen_word.length, content_length);
                    errors += field_diff("boundary_length", 32'(seen_word.count),
                                         32'(boundary_length));
                    errors += field_diff("boundary_byte", 32'(seen_word.data),
                                         32'(boundary_byte));
                    errors += field_diff("boundary_truncated", 32'(seen_word.cut),
                                         32'(boundary_truncated));
                    errors += field_diff("last_result", 32'(seen_word.last),
                                         32'(last_result));
                end
            end
            fail_count  <= errors;
            outstanding <= run_q.size();
        end
    end

endmodule

// ===== tb/tb_http_header_field_parser_core.sv =====
`timescale 1ns / 1ps
// Testbench top for http_header_field_parser_core: clock, reset, header byte stimulus
// and random receiver stalls. Depends on hhfp_pkg, the core and the result checker.
module tb_http_header_field_parser_core;

    import hhfp_pkg::*;

    localparam int unsigned MAX_BOUNDARY = 64;

    logic        clk;
    logic        rst_n;
    logic        data_valid;
    logic        data_stall;
    logic [7:0]  data_byte;
    logic        end_of_headers;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] content_length;
    logic [6:0]  boundary_length;
    logic [7:0]  boundary_byte;
    logic        boundary_truncated;
    logic        last_result;

    int fail_count;
    int outstanding;
    int words_sent = 0;
    bit calm = 1'b0;

    http_header_field_parser_core #(
        .MAX_BOUNDARY(MAX_BOUNDARY)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .data_valid        (data_valid),
        .data_stall        (data_stall),
        .data_byte         (data_byte),
        .end_of_headers    (end_of_headers),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .content_length    (content_length),
        .boundary_length   (boundary_length),
        .boundary_byte     (boundary_byte),
        .boundary_truncated(boundary_truncated),
        .last_result       (last_result)
    );

    http_header_field_parser_checker #(
        .MAX_BOUNDARY(MAX_BOUNDARY)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .data_valid        (data_valid),
        .data_stall        (data_stall),
        .data_byte         (data_byte),
        .end_of_headers    (end_of_headers),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .content_length    (content_length),
        .boundary_length   (boundary_length),
        .boundary_byte     (boundary_byte),
        .boundary_truncated(boundary_truncated),
        .last_result       (last_result),
        .fail_count        (fail_count),
        .outstanding       (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL http_header_field_parser_core");
        $finish;
    end

    always @(posedge clk)
    begin
        result_stall <= !calm && ($urandom_range(99) < 13);
    end

    task automatic put_word(input logic [7:0] b, input logic e);
        while (!calm && $urandom_range(99) < 13)
        begin
            data_valid <= 1'b0;
            @(posedge clk);
        end
        data_valid     <= 1'b1;
        data_byte      <= b;
        end_of_headers <= e;
        words_sent++;
        do @(posedge clk); while (data_stall);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_word(s[i], 1'b0);
    endtask

    task automatic put_noise(input int n);
        repeat (n) put_word(8'($urandom_range(255)), 1'b0);
    endtask

    // CR, then mostly LF but now and then any byte
    task automatic put_line(input string s);
        put_text(s);
        put_word(CR_CHAR, 1'b0);
        put_word(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'h0A, 1'b0);
    endtask

    task automatic end_request();
        put_word(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic drain();
        data_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic string rand_token(input int n);
        string      s = "";
        logic [7:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = 8'($urandom_range(32, 126));
            if (c == SEMI_CHAR)
                c = "k";
            s = $sformatf("%s%c", s, c);
        end
        return s;
    endfunction

    function automatic int boundary_size();
        return ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
    endfunction

    task automatic send_request();
        string tag;
        int    k;
        if ($urandom_range(3) == 0)
            put_noise($urandom_range(12));
        else
            put_text("GET /upload HTTP/1.1");
        put_line("");
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(9))
                0: put_line($sformatf("Content-Length: %0d", $urandom));
                1: put_line($sformatf("Content-Length: %0d %0d", $urandom_range(999), $urandom));
                2:
                begin
                    put_text("Content-Length: ");
                    put_noise($urandom_range(1, 6));
                    put_line("");
                end
                4: put_line({"Content-Type: boundary=", rand_token(boundary_size()), ";",
                             rand_token(3)});
                5: put_line("Content-Type: text/html; charset=utf-8");
                6:
                begin
                    tag = $urandom_range(1) ? "Content-Length: " : "Content-Type: ";
                    k   = $urandom_range(tag.len() - 1);
                    put_text(tag.substr(0, k - 1));
                    put_noise($urandom_range(4));
                    put_line("");
                end
                7:
                begin
                    put_text({"Content-Type: boundary=", rand_token(4)});
                    put_word(NUL_CHAR, 1'b0);
                    put_noise(3);
                    put_line("");
                end
                default: put_line({"Content-Type: multipart/form-data; boundary=",
                                   rand_token(boundary_size())});
            endcase
        end
        if ($urandom_range(4) == 0)
            put_text($sformatf("Content-Length: %0d", $urandom));
        end_request();
    endtask

    initial
    begin
        rst_n = 1'b0;
        data_valid     <= 1'b0;
        data_byte      <= 8'd0;
        end_of_headers <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        end_request();

        calm <= 1'b1;
        put_line("G");
        put_line("Content-Length: 4294967295");
        put_line({"Content-Type: a; boundary=", rand_token(70)});
        end_request();

        put_line("P");
        put_line("Content-Length: 12 3x");
        put_line({"Content-Type: boundary=", rand_token(MAX_BOUNDARY)});
        put_line("Content-Type: text/plain");
        put_line("Content-Length");
        put_line("");
        put_text("Content-Length: 99");
        end_request();
        calm <= 1'b0;

        put_line("R");
        put_line("Content-Length: 0");
        put_line("Content-Type: xboundary=boundary=bboundary=w;z");
        put_text("Content-Type: boundary=q");
        put_word(NUL_CHAR, 1'b0);
        put_line("zz");
        end_request();
        drain();

        while (words_sent < 460)
            send_request();

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS http_header_field_parser_core");
        else
            $display("FAIL http_header_field_parser_core");
        $finish;
    end

endmodule

// ===== http_header_field_parser_core.f =====
rtl/core/hhfp_pkg.sv
rtl/core/hhfp_ram.sv
rtl/core/hhfp_parser.sv
rtl/core/http_header_field_parser_core.sv
tb/http_header_field_parser_checker.sv
tb/tb_http_header_field_parser_core.sv
